FILE: sv/mips_eu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_eu_pkg
// Shared types and constants of the MIPS32 integer execute unit.
// ----------------------------------------------------------------------------
package mips_eu_pkg;

    localparam int unsigned XLEN = 32;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNIMPL  = 3'd1,
        ST_TRAP    = 3'd2,
        ST_OVF     = 3'd3,
        ST_DIVZ    = 3'd4,
        ST_SYSCALL = 3'd5,
        ST_NOTP    = 3'd6
    } status_t;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] mem_store_data;
        logic        reg_write_valid;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic [31:0] syscall_number;
        logic        load_signed;
    } result_t;

    // divider request and answer
    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

FILE: sv/mips_eu_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_eu_regfile
// 32x32 general register file, one write and two registered read ports.
// Cleared by a sweep after reset; r0 always reads zero.
// ----------------------------------------------------------------------------
module mips_eu_regfile
    import mips_eu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    output logic        clearing
);

    logic [31:0] mem [32];
    logic [5:0]  clr_cnt_reg;
    logic [4:0]  ra_q_reg;
    logic [4:0]  rb_q_reg;
    logic [31:0] da_reg;
    logic [31:0] db_reg;

    assign clearing = ~clr_cnt_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (!clr_cnt_reg[5])
        begin
            clr_cnt_reg <= clr_cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_cnt_reg[5])
        begin
            mem[clr_cnt_reg[4:0]] <= '0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        da_reg   <= mem[raddr_a];
        db_reg   <= mem[raddr_b];
        ra_q_reg <= raddr_a;
        rb_q_reg <= raddr_b;
    end

    assign rdata_a = (ra_q_reg == 5'd0) ? '0 : da_reg;
    assign rdata_b = (rb_q_reg == 5'd0) ? '0 : db_reg;

endmodule

FILE: sv/mips_eu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_eu_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mips_eu_div
    import mips_eu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        negq_reg;
    logic        negr_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [31:0] ma;
    logic [31:0] mb;

    assign ma = (req.is_signed && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
    assign mb = (req.is_signed && req.divisor[31]) ? (32'd0 - req.divisor) : req.divisor;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= ma;
            rem_reg  <= '0;
            dvs_reg  <= mb;
            negq_reg <= req.is_signed && (req.dividend[31] ^ req.divisor[31]);
            negr_reg <= req.is_signed && req.dividend[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = negq_reg ? (32'd0 - quo_reg) : quo_reg;
    assign rsp.remainder = negr_reg ? (32'd0 - rem_reg) : rem_reg;

endmodule

FILE: sv/mips32_integer_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips32_integer_execute_unit_core
// Executes MIPS32 integer instructions against a memory-based register file.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. An item passes through these steps
// before the next input transfer can be taken: the accept in S_IDLE, a read
// of rs/rt from the synchronous register file in S_READ, execution with
// write-back in S_EXEC, and the load of the output register in S_OUT. A result
// may sit in the output register while the next item runs; that item then holds
// in S_OUT until the waiting result is taken. mult/multu/mul pass through S_MUL
// for the second stage of the product; div/divu wait in S_DIV until the
// bit-serial divider is done. After reset a sweep clears the register file;
// no input transfer is taken during it. Config writes are taken at any time.
// ----------------------------------------------------------------------------
module mips32_integer_execute_unit_core
    import mips_eu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: instr_word[31:0], pc_value[63:32], load_data[95:64]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    // s_axis_tuser: req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // m_axis_tdata: status[2:0], branch_taken[3], branch_target[35:4], mem_op[37:36],
    // mem_addr[69:38], mem_size[71:70], mem_store_data[103:72], reg_write_valid[104],
    // reg_write_index[109:105], reg_write_value[141:110], syscall_number[173:142],
    // load_signed[174], zero fill up to 175
    output logic [175:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [XLEN-1:0] pwdata,
    output logic [XLEN-1:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_OUT} state_t;

    state_t      state_reg;
    logic [31:0] tp_reg;
    logic [31:0] hi_reg, lo_reg;
    logic [4:0]  pl_reg_reg;
    logic [1:0]  pl_size_reg;
    logic        pl_sign_reg;
    logic        rtype_reg;
    logic [31:0] w_reg, pc_reg, ld_reg;
    logic [63:0] prod_reg;
    logic        mul_gpr_reg;
    logic [4:0]  mul_rd_reg;
    result_t     res_reg, res;
    result_t     out_res_reg;
    logic        out_valid_reg;

    logic [31:0] a, b, rf_a, rf_b;
    logic        clearing;
    logic        we;
    logic [4:0]  waddr;
    logic [31:0] wdata;
    logic [4:0]  raddr_a, raddr_b;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // result path and pending-load bookkeeping decided in exec
    logic        hi_we, lo_we, pl_we, go_mul, go_div;
    logic [31:0] hi_n, lo_n;
    logic        mul_signed;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [31:0] simm, btgt, jtgt, ea, r_add, r_sub;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? tp_reg : '0;

    assign s_axis_tready = (state_reg == S_IDLE) && !clearing;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.load_signed, out_res_reg.syscall_number,
        out_res_reg.reg_write_value, out_res_reg.reg_write_index,
        out_res_reg.reg_write_valid, out_res_reg.mem_store_data, out_res_reg.mem_size,
        out_res_reg.mem_addr, out_res_reg.mem_op, out_res_reg.branch_target,
        out_res_reg.branch_taken, out_res_reg.status};

    // read addresses come from the held instruction; syscall reads v0 on port A
    assign raddr_a = (op == 6'h00 && fn == 6'h0C) ? 5'd2 : rs;
    assign raddr_b = rt;

    mips_eu_regfile u_rf (
        .clk(clk), .rst_n(rst_n), .raddr_a(raddr_a), .raddr_b(raddr_b),
        .rdata_a(rf_a), .rdata_b(rf_b), .we(we), .waddr(waddr), .wdata(wdata),
        .clearing(clearing)
    );

    mips_eu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign a = rf_a;
    assign b = rf_b;

    assign op   = w_reg[31:26];
    assign fn   = w_reg[5:0];
    assign rs   = w_reg[25:21];
    assign rt   = w_reg[20:16];
    assign rd   = w_reg[15:11];
    assign sa   = w_reg[10:6];
    assign imm  = w_reg[15:0];
    assign simm = sx16(imm);
    assign btgt = pc_reg + {simm[29:0], 2'b00};
    assign jtgt = {w_reg[25:0], 2'b00} | (pc_reg & PC_REGION_MASK);
    assign ea   = a + simm;
    assign r_add = a + b;
    assign r_sub = a - b;

    // register write helper lives in the exec comb block below
    always_comb
    begin
        logic [4:0]  wi;
        logic [31:0] wv;
        logic        wr;
        logic [31:0] ld_v;
        logic [31:0] ext_v;
        res = '0;
        wi = '0;
        wv = '0;
        wr = 1'b0;
        hi_we = 1'b0;
        lo_we = 1'b0;
        hi_n = a;
        lo_n = a;
        pl_we = 1'b0;
        go_mul = 1'b0;
        go_div = 1'b0;
        mul_signed = 1'b0;
        ld_v = '0;
        ext_v = '0;
        if (rtype_reg)
        begin
            case (pl_size_reg)
                SZ_BYTE: ld_v = pl_sign_reg ? sx8(ld_reg[7:0]) : {24'd0, ld_reg[7:0]};
                SZ_HALF: ld_v = pl_sign_reg ? sx16(ld_reg[15:0]) : {16'd0, ld_reg[15:0]};
                default: ld_v = ld_reg;
            endcase
            wr = 1'b1;
            wi = pl_reg_reg;
            wv = ld_v;
        end
        else
        begin
            case (op)
                6'h00:
                begin
                    case (fn)
                        6'h00: begin wr = 1'b1; wi = rd; wv = b << sa; end
                        6'h02: begin wr = 1'b1; wi = rd; wv = b >> sa; end
                        6'h03: begin wr = 1'b1; wi = rd; wv = $signed(b) >>> sa; end
                        6'h04: begin wr = 1'b1; wi = rd; wv = b << a[4:0]; end
                        6'h08: begin res.branch_taken = 1'b1; res.branch_target = a; end
                        6'h09:
                        begin
                            wr = 1'b1; wi = rd; wv = pc_reg + 32'd4;
                            res.branch_taken = 1'b1; res.branch_target = a;
                        end
                        6'h0A: begin wr = (b == '0); wi = rd; wv = a; end
                        6'h0B: begin wr = (b != '0); wi = rd; wv = a; end
                        6'h0C: res.status = ST_SYSCALL;
                        6'h0F: ;
                        6'h10: begin wr = 1'b1; wi = rd; wv = hi_reg; end
                        6'h11: hi_we = 1'b1;
                        6'h12: begin wr = 1'b1; wi = rd; wv = lo_reg; end
                        6'h13: lo_we = 1'b1;
                        6'h18: begin go_mul = 1'b1; mul_signed = 1'b1; end
                        6'h19: go_mul = 1'b1;
                        6'h1A, 6'h1B:
                        begin
                            if (b == '0) res.status = ST_DIVZ;
                            else go_div = 1'b1;
                        end
                        6'h20:
                        begin
                            if ((a[31] ~^ b[31]) && (r_add[31] != a[31]))
                                res.status = ST_OVF;
                            else begin wr = 1'b1; wi = rd; wv = r_add; end
                        end
                        6'h21: begin wr = 1'b1; wi = rd; wv = r_add; end
                        6'h22:
                        begin
                            if ((a[31] ^ b[31]) && (r_sub[31] != a[31]))
                                res.status = ST_OVF;
                            else begin wr = 1'b1; wi = rd; wv = r_sub; end
                        end
                        6'h23: begin wr = 1'b1; wi = rd; wv = r_sub; end
                        6'h24: begin wr = 1'b1; wi = rd; wv = a & b; end
                        6'h25: begin wr = 1'b1; wi = rd; wv = a | b; end
                        6'h26: begin wr = 1'b1; wi = rd; wv = a ^ b; end
                        6'h27: begin wr = 1'b1; wi = rd; wv = ~(a | b); end
                        6'h2A: begin wr = 1'b1; wi = rd; wv = {31'd0, $signed(a) < $signed(b)}; end
                        6'h2B: begin wr = 1'b1; wi = rd; wv = {31'd0, a < b}; end
                        6'h34: if (a == b) res.status = ST_TRAP;
                        default: res.status = ST_UNIMPL;
                    endcase
                end
                6'h01:
                begin
                    case (rt)
                        5'h00: begin res.branch_taken = a[31]; res.branch_target = btgt; end
                        5'h01: begin res.branch_taken = ~a[31]; res.branch_target = btgt; end
                        5'h11:
                        begin
                            wr = 1'b1; wi = 5'd31; wv = pc_reg + 32'd4;
                            res.branch_taken = ~a[31]; res.branch_target = btgt;
                        end
                        default: res.status = ST_UNIMPL;
                    endcase
                end
                6'h02: begin res.branch_taken = 1'b1; res.branch_target = jtgt; end
                6'h03:
                begin
                    wr = 1'b1; wi = 5'd31; wv = pc_reg + 32'd4;
                    res.branch_taken = 1'b1; res.branch_target = jtgt;
                end
                6'h04: begin res.branch_taken = (a == b); res.branch_target = btgt; end
                6'h05: begin res.branch_taken = (a != b); res.branch_target = btgt; end
                6'h06: begin res.branch_taken = (a == '0) || a[31]; res.branch_target = btgt; end
                6'h07: begin res.branch_taken = (a != '0) && !a[31]; res.branch_target = btgt; end
                6'h09: begin wr = 1'b1; wi = rt; wv = a + simm; end
                6'h0A: begin wr = 1'b1; wi = rt; wv = {31'd0, $signed(a) < $signed(simm)}; end
                6'h0B: begin wr = 1'b1; wi = rt; wv = {31'd0, a < simm}; end
                6'h0C: begin wr = 1'b1; wi = rt; wv = a & {16'd0, imm}; end
                6'h0D: begin wr = 1'b1; wi = rt; wv = a | {16'd0, imm}; end
                6'h0E: begin wr = 1'b1; wi = rt; wv = a ^ {16'd0, imm}; end
                6'h0F: begin wr = 1'b1; wi = rt; wv = {imm, 16'd0}; end
                6'h1C:
                begin
                    if (fn == 6'h02) go_mul = 1'b1;
                    else res.status = ST_UNIMPL;
                end
                6'h1F:
                begin
                    case (fn)
                        6'h00:
                        begin
                            ext_v = a >> sa;
                            if (rd != 5'd31)
                                ext_v = ext_v & ~(32'hFFFF_FFFF << (rd + 5'd1));
                            wr = 1'b1; wi = rt; wv = ext_v;
                        end
                        6'h20:
                        begin
                            if (sa == 5'b10000) begin wr = 1'b1; wi = rd; wv = sx8(b[7:0]); end
                            else if (sa == 5'b11000) begin wr = 1'b1; wi = rd; wv = sx16(b[15:0]); end
                            else res.status = ST_UNIMPL;
                        end
                        6'h3B:
                        begin
                            if (rd != 5'd29) res.status = ST_UNIMPL;
                            else if (tp_reg == '0) res.status = ST_NOTP;
                            else begin wr = 1'b1; wi = rt; wv = tp_reg; end
                        end
                        default: res.status = ST_UNIMPL;
                    endcase
                end
                6'h20, 6'h21, 6'h23, 6'h24, 6'h25, 6'h30:
                begin
                    pl_we = 1'b1;
                    res.mem_op = MEM_LOAD;
                    res.mem_addr = ea;
                    res.mem_size = (op == 6'h20 || op == 6'h24) ? SZ_BYTE :
                                   (op == 6'h21 || op == 6'h25) ? SZ_HALF : SZ_WORD;
                    res.load_signed = (op == 6'h20 || op == 6'h21);
                end
                6'h28, 6'h29, 6'h2B, 6'h38:
                begin
                    res.mem_op = MEM_STORE;
                    res.mem_addr = ea;
                    res.mem_size = (op == 6'h28) ? SZ_BYTE : (op == 6'h29) ? SZ_HALF : SZ_WORD;
                    res.mem_store_data = (op == 6'h28) ? {24'd0, b[7:0]} :
                                         (op == 6'h29) ? {16'd0, b[15:0]} : b;
                    if (op == 6'h38) begin wr = 1'b1; wi = rt; wv = 32'd1; end
                end
                6'h33: ;
                default: res.status = ST_UNIMPL;
            endcase
        end
        // port A carries v0 for syscall
        if (res.status == ST_SYSCALL)
            res.syscall_number = a;
        if (wr && wi != 5'd0)
        begin
            res.reg_write_valid = 1'b1;
            res.reg_write_index = wi;
            res.reg_write_value = wv;
        end
    end

    // write port: exec writes, mul second stage writes mul rd
    always_comb
    begin
        we = 1'b0;
        waddr = res.reg_write_index;
        wdata = res.reg_write_value;
        if (state_reg == S_EXEC)
            we = res.reg_write_valid;
        else if (state_reg == S_MUL && mul_gpr_reg && mul_rd_reg != 5'd0)
        begin
            we = 1'b1;
            waddr = mul_rd_reg;
            wdata = prod_reg[31:0];
        end
    end

    assign dreq.start     = (state_reg == S_EXEC) && go_div;
    assign dreq.is_signed = ~fn[0];
    assign dreq.dividend  = a;
    assign dreq.divisor   = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tp_reg        <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pl_reg_reg    <= '0;
            pl_size_reg   <= '0;
            pl_sign_reg   <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 1'b0)
                tp_reg <= pwdata;
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                        state_reg <= S_READ;
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (rtype_reg)
                        pl_reg_reg <= '0;
                    if (pl_we)
                    begin
                        pl_reg_reg  <= rt;
                        pl_size_reg <= res.mem_size;
                        pl_sign_reg <= res.load_signed;
                    end
                    if (hi_we) hi_reg <= hi_n;
                    if (lo_we) lo_reg <= lo_n;
                    if (go_mul) state_reg <= S_MUL;
                    else if (go_div) state_reg <= S_DIV;
                    else state_reg <= S_OUT;
                end
                S_MUL:
                begin
                    if (!mul_gpr_reg)
                    begin
                        hi_reg <= prod_reg[63:32];
                        lo_reg <= prod_reg[31:0];
                    end
                    state_reg <= S_OUT;
                end
                S_DIV:
                    if (drsp.done)
                    begin
                        hi_reg <= drsp.remainder;
                        lo_reg <= drsp.quotient;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_valid_reg || m_axis_tready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            rtype_reg <= s_axis_tuser;
            w_reg     <= s_axis_tdata[31:0];
            pc_reg    <= s_axis_tdata[63:32];
            ld_reg    <= s_axis_tdata[95:64];
        end
        if (state_reg == S_EXEC)
        begin
            res_reg     <= res;
            mul_gpr_reg <= (op == 6'h1C);
            mul_rd_reg  <= rd;
            if (mul_signed)
                prod_reg <= 64'($signed(a) * $signed(b));
            else
                prod_reg <= {32'd0, a} * {32'd0, b};
        end
        else if (state_reg == S_MUL && mul_gpr_reg && mul_rd_reg != 5'd0)
        begin
            res_reg.reg_write_valid <= 1'b1;
            res_reg.reg_write_index <= mul_rd_reg;
            res_reg.reg_write_value <= prod_reg[31:0];
        end
        // output register, loaded only when the previous result is gone
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            out_res_reg <= res_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !go_mul && !go_div) |=> state_reg == S_OUT)
        else $error("exec did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("input taken during clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && rtype_reg) |=> pl_reg_reg == 5'd0)
        else $error("pending load not cleared");

endmodule
